### rtl/sensor_report_by_exception_macros.svh
// Assertion macros for the checker file of the sensor report block.
// Depends on nothing; each macro expects clock and reset in scope.
`ifndef SENSOR_REPORT_BY_EXCEPTION_MACROS_SVH
`define SENSOR_REPORT_BY_EXCEPTION_MACROS_SVH

// Same-cycle implication, sampled at the rising edge, off during reset.
`define SRBE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sensor report check failed");

// Next-cycle implication, sampled at the rising edge, off during reset.
`define SRBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sensor report check failed");

`endif

### rtl/srbe_pkg.sv
// Types and constants of the sensor report-by-exception block.
// Used by the top level and by its port checker; depends on nothing.
package srbe_pkg;

   // Channel count and tick arithmetic
   localparam int CHANNELS = 4;
   localparam logic [6:0] TICK_UNIT = 7'd100;
   localparam logic [23:0] TICK_MAX = 24'hFF_FFFF;

   // Configuration register indexes (byte address is 8 times the index)
   typedef enum logic [2:0] {
      REG_CHANNEL_ENABLES   = 3'd0,
      REG_INTERVAL_TABLE    = 3'd1,
      REG_DEADBAND_TABLE    = 3'd2,
      REG_UPPER_LIMIT_TABLE = 3'd3,
      REG_LOWER_LIMIT_TABLE = 3'd4,
      REG_SENSOR_VALID_MASK = 3'd5
   } reg_index_type;

   // Report causes
   typedef enum logic [1:0] {
      CAUSE_NONE     = 2'd0,
      CAUSE_INTERVAL = 2'd1,
      CAUSE_CHANGE   = 2'd2,
      CAUSE_RANGE    = 2'd3
   } cause_type;

   // Input beat
   typedef struct packed {
      logic [1:0]         channel;
      logic               condition_met;
      logic signed [15:0] sensor_value;
      logic [15:0]        elapsed;
   } req_type;

   // Result beat
   typedef struct packed {
      logic      alarm_start;
      logic      alarm_stop;
      logic [1:0] report_cause;
   } rsp_type;

   // One channel's entry in the state memory
   typedef struct packed {
      logic               alarm_active;
      logic [23:0]        tick_count;
      logic signed [15:0] last_value;
   } chan_state_type;

endpackage

### rtl/sensor_report_by_exception.sv
// Sensor report-by-exception supervisor: alarm edges and report decisions per channel.
// Depends on srbe_pkg for beat types, register indexes and cause codes.
//
// Usage:
//   req_* carries one beat per sample: channel, external trigger result, sample and
//   ticks since the channel's previous beat. rsp_* returns exactly one beat per
//   request, in order: alarm start/stop flags and the report cause.
//   The APB-style port writes the six configuration registers at byte address 8*i;
//   write them only while no beat is in flight. pready is tied high.
// Pipeline:
//   An accepted request is registered in the compute stage, and its result then in
//   the result register. One beat per cycle is sustained while rsp_ready is high:
//   the state memory is read at acceptance and written back when the stage
//   advances, and a read of the entry being written takes the new data directly.
// Reset:
//   Control and configuration registers clear to zero; per-entry valid bits make every
//   channel's state read as zero until first written, so no clearing pass is needed.
// Stall:
//   When rsp_ready is low the result register holds, the computing stage holds
//   behind it, and req_ready drops until the result register can move.
module sensor_report_by_exception (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srbe_pkg::req_type     req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output srbe_pkg::rsp_type     rsp_data,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [5:0]            paddr,
   input  logic [63:0]           pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   // Configuration registers
   logic [7:0]  enables_ff;
   logic [63:0] interval_ff;
   logic [63:0] deadband_ff;
   logic [63:0] upper_ff;
   logic [63:0] lower_ff;
   logic [3:0]  valid_mask_ff;

   srbe_pkg::reg_index_type csr_index;
   logic                    csr_write;

   // State memory and its valid bits
   srbe_pkg::chan_state_type state_mem [srbe_pkg::CHANNELS];
   logic [srbe_pkg::CHANNELS-1:0] row_valid_ff;
   srbe_pkg::chan_state_type rd_data_ff;
   logic                     rd_hit_ff;

   // Compute stage
   logic              s1_valid_ff;
   srbe_pkg::req_type s1_req_ff;
   logic              s1_go;
   logic              req_take;
   logic              chan_ok;

   // Result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   srbe_pkg::rsp_type rsp_data_ff;
   srbe_pkg::rsp_type rsp_data_in;

   // Latch shared by all channels
   logic range_latch_ff;
   logic range_latch_in;

   // Write-back bus
   logic                     wr_en;
   logic [1:0]               wr_addr;
   srbe_pkg::chan_state_type wr_data;

   // Datapath of the compute stage
   srbe_pkg::chan_state_type cur;
   logic               trig_en;
   logic               alarm_en;
   logic               sens_ok;
   logic               cond_eff;
   logic [15:0]        ival;
   logic [15:0]        band;
   logic signed [15:0] hi;
   logic signed [15:0] lo;
   logic [22:0]        thr;
   logic [24:0]        tsum;
   logic [23:0]        tsat;
   logic signed [16:0] diff;
   logic [16:0]        mag;
   logic               out_range;
   srbe_pkg::cause_type cause;

   //--------------------------------------------------------------------------
   // Configuration port
   //--------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_index = srbe_pkg::reg_index_type'(paddr[5:3]);
   assign csr_write = psel && penable && pwrite;

   // Write registers on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         enables_ff    <= '0;
         interval_ff   <= '0;
         deadband_ff   <= '0;
         upper_ff      <= '0;
         lower_ff      <= '0;
         valid_mask_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            srbe_pkg::REG_CHANNEL_ENABLES:   enables_ff    <= pwdata[7:0];
            srbe_pkg::REG_INTERVAL_TABLE:    interval_ff   <= pwdata;
            srbe_pkg::REG_DEADBAND_TABLE:    deadband_ff   <= pwdata;
            srbe_pkg::REG_UPPER_LIMIT_TABLE: upper_ff      <= pwdata;
            srbe_pkg::REG_LOWER_LIMIT_TABLE: lower_ff      <= pwdata;
            srbe_pkg::REG_SENSOR_VALID_MASK: valid_mask_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_index)
         srbe_pkg::REG_CHANNEL_ENABLES:   prdata = {56'd0, enables_ff};
         srbe_pkg::REG_INTERVAL_TABLE:    prdata = interval_ff;
         srbe_pkg::REG_DEADBAND_TABLE:    prdata = deadband_ff;
         srbe_pkg::REG_UPPER_LIMIT_TABLE: prdata = upper_ff;
         srbe_pkg::REG_LOWER_LIMIT_TABLE: prdata = lower_ff;
         srbe_pkg::REG_SENSOR_VALID_MASK: prdata = {60'd0, valid_mask_ff};
         default:                         prdata = '0;
      endcase
   end

   //--------------------------------------------------------------------------
   // Handshake
   //--------------------------------------------------------------------------
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;
   assign chan_ok   = (int'(req_data.channel) < srbe_pkg::CHANNELS);

   // Advance the compute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
   end

   //--------------------------------------------------------------------------
   // State memory: read at acceptance, written back when the stage advances
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         state_mem[wr_addr] <= wr_data;
      end
      if (req_take && chan_ok) begin
         if (wr_en && (wr_addr == req_data.channel)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= state_mem[req_data.channel];
         end
      end
   end

   // Track written entries; forward the valid bit with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (req_take && chan_ok) begin
            rd_hit_ff <= (wr_en && (wr_addr == req_data.channel))
                         || row_valid_ff[req_data.channel];
         end
      end
   end

   //--------------------------------------------------------------------------
   // Compute stage
   //--------------------------------------------------------------------------
   always_comb begin
      // Unwritten entries read as zero
      cur = rd_hit_ff ? rd_data_ff : '0;

      trig_en  = enables_ff[{s1_req_ff.channel, 1'b0}];
      alarm_en = enables_ff[{s1_req_ff.channel, 1'b1}];
      sens_ok  = valid_mask_ff[s1_req_ff.channel];
      cond_eff = s1_req_ff.condition_met && sens_ok;

      ival = interval_ff[16*s1_req_ff.channel +: 16];
      band = deadband_ff[16*s1_req_ff.channel +: 16];
      hi   = signed'(upper_ff[16*s1_req_ff.channel +: 16]);
      lo   = signed'(lower_ff[16*s1_req_ff.channel +: 16]);

      // Interval threshold, saturating tick sum, change magnitude
      thr  = 23'(ival) * 23'(srbe_pkg::TICK_UNIT);
      tsum = {1'b0, cur.tick_count} + 25'(s1_req_ff.elapsed);
      tsat = tsum[24] ? srbe_pkg::TICK_MAX : tsum[23:0];
      diff = 17'(s1_req_ff.sensor_value) - 17'(cur.last_value);
      mag  = diff[16] ? 17'(-diff) : 17'(diff);
      out_range = (s1_req_ff.sensor_value > hi) || (s1_req_ff.sensor_value < lo);

      // Defaults: keep state, empty result
      wr_data        = cur;
      range_latch_in = range_latch_ff;
      rsp_data_in    = '0;
      cause          = srbe_pkg::CAUSE_NONE;

      if (trig_en) begin
         // Alarm edges
         if (alarm_en) begin
            if (cond_eff && !cur.alarm_active) begin
               rsp_data_in.alarm_start = 1'b1;
               wr_data.alarm_active    = 1'b1;
            end else if (!cond_eff && cur.alarm_active) begin
               rsp_data_in.alarm_stop = 1'b1;
               wr_data.alarm_active   = 1'b0;
            end
         end else begin
            wr_data.alarm_active = 1'b0;
         end

         // Report decision, in priority order
         if (sens_ok) begin
            if ({1'b0, tsat} >= {2'b00, thr}) begin
               cause = srbe_pkg::CAUSE_INTERVAL;
            end else if (mag > {1'b0, band}) begin
               cause = srbe_pkg::CAUSE_CHANGE;
            end else if (out_range) begin
               if (!range_latch_ff) begin
                  range_latch_in = 1'b1;
                  cause          = srbe_pkg::CAUSE_RANGE;
               end
            end else begin
               range_latch_in = 1'b0;
            end
            wr_data.tick_count = (cause != srbe_pkg::CAUSE_NONE) ? 24'd0 : tsat;
            wr_data.last_value = s1_req_ff.sensor_value;
         end
      end
      rsp_data_in.report_cause = cause;
   end

   assign wr_en   = s1_go && (int'(s1_req_ff.channel) < srbe_pkg::CHANNELS);
   assign wr_addr = s1_req_ff.channel;

   // Hold the latch until the stage advances
   always_ff @(posedge clock) begin
      if (reset) begin
         range_latch_ff <= 1'b0;
      end else if (wr_en) begin
         range_latch_ff <= range_latch_in;
      end
   end

   //--------------------------------------------------------------------------
   // Result register
   //--------------------------------------------------------------------------
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load a result; drop it for channels beyond the count
   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_data_ff <= wr_en ? rsp_data_in : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/srbe_checker.sv
// Port-level checker for the sensor report block, bound to its top level.
// Depends on srbe_pkg and on sensor_report_by_exception_macros.svh.
`include "sensor_report_by_exception_macros.svh"

module srbe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input srbe_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input srbe_pkg::rsp_type rsp_data
);

   // A stalled result beat holds its value
   `SRBE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // One alarm edge per beat at most
   `SRBE_ASSERT_NOW(a_one_edge, rsp_valid, !(rsp_data.alarm_start && rsp_data.alarm_stop))

   // Every accepted request has a result beat waiting afterwards
   `SRBE_ASSERT_NOW(a_latency, req_valid && req_ready, ##2 rsp_valid)

   // Nothing is offered right after reset
   `SRBE_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid)

endmodule

bind sensor_report_by_exception srbe_checker u_srbe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
